// ----- rtl/cst_pkg.sv -----
package cst_pkg;

    localparam int POSITION_BITS   = 16;
    localparam int OFFSET_BITS     = 32;
    localparam int KEYWORD_MAX_LEN = 8;
    localparam int LEN_BITS        = 16;
    localparam int KIND_BITS       = 7;
    localparam int ERR_BITS        = 3;
    localparam int MAX_RESULTS     = 3;

    localparam logic [KIND_BITS-1:0] K_IDENT    = 7'd24;
    localparam logic [KIND_BITS-1:0] K_INTLIT   = 7'd25;
    localparam logic [KIND_BITS-1:0] K_FLOATLIT = 7'd26;
    localparam logic [KIND_BITS-1:0] K_CHARLIT  = 7'd27;
    localparam logic [KIND_BITS-1:0] K_STRLIT   = 7'd28;
    localparam logic [KIND_BITS-1:0] K_EOF      = 7'd72;
    localparam logic [KIND_BITS-1:0] K_NONE     = 7'd0;

    // operator kinds
    localparam logic [KIND_BITS-1:0] OP_PLUS   = 7'd29;
    localparam logic [KIND_BITS-1:0] OP_MINUS  = 7'd30;
    localparam logic [KIND_BITS-1:0] OP_STAR   = 7'd31;
    localparam logic [KIND_BITS-1:0] OP_SLASH  = 7'd32;
    localparam logic [KIND_BITS-1:0] OP_EQEQ   = 7'd33;
    localparam logic [KIND_BITS-1:0] OP_NE     = 7'd34;
    localparam logic [KIND_BITS-1:0] OP_LT     = 7'd35;
    localparam logic [KIND_BITS-1:0] OP_GT     = 7'd36;
    localparam logic [KIND_BITS-1:0] OP_LE     = 7'd37;
    localparam logic [KIND_BITS-1:0] OP_GE     = 7'd38;
    localparam logic [KIND_BITS-1:0] OP_ANDAND = 7'd39;
    localparam logic [KIND_BITS-1:0] OP_OROR   = 7'd40;
    localparam logic [KIND_BITS-1:0] OP_NOT    = 7'd41;
    localparam logic [KIND_BITS-1:0] OP_AND    = 7'd42;
    localparam logic [KIND_BITS-1:0] OP_OR     = 7'd43;
    localparam logic [KIND_BITS-1:0] OP_XOR    = 7'd44;
    localparam logic [KIND_BITS-1:0] OP_TILDE  = 7'd45;
    localparam logic [KIND_BITS-1:0] OP_SHL    = 7'd46;
    localparam logic [KIND_BITS-1:0] OP_SHR    = 7'd47;
    localparam logic [KIND_BITS-1:0] OP_QUEST  = 7'd48;
    localparam logic [KIND_BITS-1:0] OP_COLON  = 7'd49;
    localparam logic [KIND_BITS-1:0] OP_INC    = 7'd50;
    localparam logic [KIND_BITS-1:0] OP_DEC    = 7'd51;
    localparam logic [KIND_BITS-1:0] OP_ADDEQ  = 7'd52;
    localparam logic [KIND_BITS-1:0] OP_SUBEQ  = 7'd53;
    localparam logic [KIND_BITS-1:0] OP_MULEQ  = 7'd54;
    localparam logic [KIND_BITS-1:0] OP_DIVEQ  = 7'd55;
    localparam logic [KIND_BITS-1:0] OP_ANDEQ  = 7'd56;
    localparam logic [KIND_BITS-1:0] OP_OREQ   = 7'd57;
    localparam logic [KIND_BITS-1:0] OP_XOREQ  = 7'd58;
    localparam logic [KIND_BITS-1:0] OP_SHLEQ  = 7'd59;
    localparam logic [KIND_BITS-1:0] OP_SHREQ  = 7'd60;
    localparam logic [KIND_BITS-1:0] OP_ASSIGN = 7'd61;
    localparam logic [KIND_BITS-1:0] OP_LPAREN = 7'd62;
    localparam logic [KIND_BITS-1:0] OP_RPAREN = 7'd63;
    localparam logic [KIND_BITS-1:0] OP_LBRACE = 7'd64;
    localparam logic [KIND_BITS-1:0] OP_RBRACE = 7'd65;
    localparam logic [KIND_BITS-1:0] OP_LBRACK = 7'd66;
    localparam logic [KIND_BITS-1:0] OP_RBRACK = 7'd67;
    localparam logic [KIND_BITS-1:0] OP_SEMI   = 7'd68;
    localparam logic [KIND_BITS-1:0] OP_COMMA  = 7'd69;
    localparam logic [KIND_BITS-1:0] OP_DOT    = 7'd70;
    localparam logic [KIND_BITS-1:0] OP_ARROW  = 7'd71;

    // error codes
    localparam logic [ERR_BITS-1:0] ERR_NONE     = 3'd0;
    localparam logic [ERR_BITS-1:0] ERR_BADCHAR  = 3'd1;
    localparam logic [ERR_BITS-1:0] ERR_EXPDIG   = 3'd2;
    localparam logic [ERR_BITS-1:0] ERR_CHOPEN   = 3'd3;
    localparam logic [ERR_BITS-1:0] ERR_CHLONG   = 3'd4;
    localparam logic [ERR_BITS-1:0] ERR_STRING   = 3'd5;

    typedef enum logic [3:0] {
        M_IDLE, M_COMMENT, M_OP, M_IDENT, M_INT, M_FRAC, M_EXP, M_EXPSIGN,
        M_EXPDIG, M_CHOPEN, M_CHESC, M_CHCLOSE, M_STR, M_STRESC, M_ERROR
    } scan_mode_t;

    typedef struct packed {
        logic [KIND_BITS-1:0]     kind;
        logic [ERR_BITS-1:0]      err;
        logic [POSITION_BITS-1:0] line;
        logic [POSITION_BITS-1:0] column;
        logic [OFFSET_BITS-1:0]   offset;
        logic [LEN_BITS-1:0]      length;
        logic                     last;
    } result_t;

    // keyword spellings, first byte in the low byte
    localparam logic [63:0] KW_WORD [24] = '{
        64'h746e69, 64'h74616f6c66, 64'h72616863, 64'h64696f76,
        64'h6669, 64'h65736c65, 64'h656c696877, 64'h726f66,
        64'h6e7275746572, 64'h6b61657262, 64'h65756e69746e6f63, 64'h6f64,
        64'h686374697773, 64'h65736163, 64'h746c7561666564, 64'h6f746f67,
        64'h666f657a6973, 64'h74736e6f63, 64'h636974617473, 64'h6e7265747865,
        64'h656c6974616c6f76, 64'h746375727473, 64'h6e6f696e75, 64'h6d756e65
    };
    localparam logic [3:0] KW_LEN [24] = '{
        4'd3, 4'd5, 4'd4, 4'd4, 4'd2, 4'd4, 4'd5, 4'd3,
        4'd6, 4'd5, 4'd8, 4'd2, 4'd6, 4'd4, 4'd7, 4'd4,
        4'd6, 4'd5, 4'd6, 4'd6, 4'd8, 4'd6, 4'd5, 4'd4
    };

    function automatic logic [KIND_BITS-1:0] ident_kind(
        input logic [63:0] buffer, input logic [LEN_BITS-1:0] len, input logic long_flag);
        logic [KIND_BITS-1:0] k;
        k = K_IDENT;
        if (!long_flag && len <= LEN_BITS'(KEYWORD_MAX_LEN)) begin
            for (int i = 23; i >= 0; i--) begin
                if (buffer == KW_WORD[i] && len == LEN_BITS'(KW_LEN[i]))
                    k = KIND_BITS'(i);
            end
        end
        return k;
    endfunction

    function automatic logic [KIND_BITS-1:0] op_lead(input logic [7:0] b);
        case (b)
            "+": return OP_PLUS;
            "-": return OP_MINUS;
            "*": return OP_STAR;
            "/": return OP_SLASH;
            "=": return OP_ASSIGN;
            "!": return OP_NOT;
            "<": return OP_LT;
            ">": return OP_GT;
            "&": return OP_AND;
            "|": return OP_OR;
            "^": return OP_XOR;
            default: return K_NONE;
        endcase
    endfunction

    function automatic logic [KIND_BITS-1:0] op_single(input logic [7:0] b);
        case (b)
            "~": return OP_TILDE;
            "?": return OP_QUEST;
            ":": return OP_COLON;
            "(": return OP_LPAREN;
            ")": return OP_RPAREN;
            "{": return OP_LBRACE;
            "}": return OP_RBRACE;
            "[": return OP_LBRACK;
            "]": return OP_RBRACK;
            ";": return OP_SEMI;
            ",": return OP_COMMA;
            ".": return OP_DOT;
            default: return K_NONE;
        endcase
    endfunction

    function automatic logic [KIND_BITS-1:0] op_extend(
        input logic [KIND_BITS-1:0] p, input logic [7:0] b);
        logic [KIND_BITS-1:0] k;
        k = K_NONE;
        case (p)
            OP_PLUS:   k = (b == "+") ? OP_INC : (b == "=") ? OP_ADDEQ : K_NONE;
            OP_MINUS:  k = (b == ">") ? OP_ARROW : (b == "-") ? OP_DEC :
                           (b == "=") ? OP_SUBEQ : K_NONE;
            OP_STAR:   k = (b == "=") ? OP_MULEQ : K_NONE;
            OP_SLASH:  k = (b == "=") ? OP_DIVEQ : K_NONE;
            OP_ASSIGN: k = (b == "=") ? OP_EQEQ : K_NONE;
            OP_NOT:    k = (b == "=") ? OP_NE : K_NONE;
            OP_LT:     k = (b == "<") ? OP_SHL : (b == "=") ? OP_LE : K_NONE;
            OP_GT:     k = (b == ">") ? OP_SHR : (b == "=") ? OP_GE : K_NONE;
            OP_SHL:    k = (b == "=") ? OP_SHLEQ : K_NONE;
            OP_SHR:    k = (b == "=") ? OP_SHREQ : K_NONE;
            OP_AND:    k = (b == "&") ? OP_ANDAND : (b == "=") ? OP_ANDEQ : K_NONE;
            OP_OR:     k = (b == "|") ? OP_OROR : (b == "=") ? OP_OREQ : K_NONE;
            OP_XOR:    k = (b == "=") ? OP_XOREQ : K_NONE;
            default:   k = K_NONE;
        endcase
        return k;
    endfunction

    function automatic logic is_alpha(input logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic logic [LEN_BITS-1:0] sat_inc(input logic [LEN_BITS-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

endpackage

// ----- rtl/c_subset_token_scanner_top.sv -----
// C-subset token scanner.
// Input channel s_axis: one source byte per item in tdata, tlast marks the
// last byte of a source. Output channel m_axis: one token per item; tdata holds
// kind, error code, start line, start column, start offset and length, and
// tlast marks the last token caused by one input byte.
// Each byte is scanned in the cycle it is accepted; its tokens (up to three)
// are loaded into a three-entry result register and shown from the next cycle,
// one per cycle while the receiver does not stall.
// Throughput is one byte per cycle while each byte yields at most one token
// and the receiver does not stall; a byte that yields more tokens holds the input
// until the output port has drained the result register to its last token.
// A new byte is taken while the last pending token is being taken.
// When the receiver stalls, the pending tokens hold and tready stays low while
// any token is pending.
// Reset (rst_n low) returns to line 1, column 1, offset 0, between tokens,
// with no pending tokens. After an error token, bytes are dropped until the
// end-marked byte, which restarts the scanner without an end token.
module c_subset_token_scanner_top
    import cst_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // in_byte
    input  logic        s_axis_tlast,   // end_after
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // token_kind[6:0], error_code[9:7], start_line[25:10], start_column[41:26],
    // start_offset[73:42], token_length[89:74], zero fill[95:90]
    output logic [95:0] m_axis_tdata,
    output logic        m_axis_tlast    // last_of_run
);

    // scanner state
    scan_mode_t               mode_reg, mode_next;
    logic [KIND_BITS-1:0]     pend_reg, pend_next;
    logic [POSITION_BITS-1:0] line_reg, line_next, col_reg, col_next;
    logic [OFFSET_BITS-1:0]   off_reg, off_next;
    logic [POSITION_BITS-1:0] ts_line_reg, ts_line_next, ts_col_reg, ts_col_next;
    logic [OFFSET_BITS-1:0]   ts_off_reg, ts_off_next;
    logic [LEN_BITS-1:0]      len_reg, len_next;
    logic [63:0]              kbuf_reg, kbuf_next;
    logic                     long_reg, long_next;

    // result register
    result_t                  res_reg [MAX_RESULTS];
    result_t                  res_next [MAX_RESULTS];
    logic [1:0]               count_reg, nres;
    logic [1:0]               head_reg;

    logic in_fire, out_fire;
    logic [7:0] b;
    logic rescan;
    logic [KIND_BITS-1:0] k;

    assign b        = s_axis_tdata;
    assign out_fire = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = (count_reg == 2'd0) || (count_reg == 2'd1 && m_axis_tready);
    assign in_fire  = s_axis_tvalid && s_axis_tready;

    function automatic result_t mk(
        input logic [KIND_BITS-1:0] kind, input logic [ERR_BITS-1:0] err,
        input logic [POSITION_BITS-1:0] l, input logic [POSITION_BITS-1:0] c,
        input logic [OFFSET_BITS-1:0] o, input logic [LEN_BITS-1:0] n);
        result_t r;
        r.kind = kind; r.err = err; r.line = l; r.column = c;
        r.offset = o; r.length = n; r.last = 1'b0;
        return r;
    endfunction

    // scan one byte
    always_comb
    begin
        mode_next    = mode_reg;
        pend_next    = pend_reg;
        ts_line_next = ts_line_reg;
        ts_col_next  = ts_col_reg;
        ts_off_next  = ts_off_reg;
        len_next     = len_reg;
        kbuf_next    = kbuf_reg;
        long_next    = long_reg;
        nres         = 2'd0;
        rescan       = 1'b0;
        k            = K_NONE;
        for (int i = 0; i < MAX_RESULTS; i++)
            res_next[i] = mk(K_NONE, ERR_NONE, '0, '0, '0, '0);

        // continue the open token
        case (mode_reg)
            M_COMMENT:
            begin
                if (b == 8'h0a) mode_next = M_IDLE;
            end
            M_OP:
            begin
                k = op_extend(pend_reg, b);
                if (pend_reg == OP_SLASH && b == "/") begin
                    mode_next = M_COMMENT;
                end else if (k == K_NONE) begin
                    res_next[nres] = mk(pend_reg, ERR_NONE, ts_line_next, ts_col_next,
                                        ts_off_next, len_next);
                    nres = nres + 1'b1;
                    mode_next = M_IDLE;
                    rescan = 1'b1;
                end else begin
                    len_next = sat_inc(len_next);
                    if (k == OP_SHL || k == OP_SHR) begin
                        pend_next = k;
                    end else begin
                        res_next[nres] = mk(k, ERR_NONE, ts_line_next, ts_col_next,
                                            ts_off_next, len_next);
                        nres = nres + 1'b1;
                        mode_next = M_IDLE;
                    end
                end
            end
            M_IDENT:
            begin
                if (is_alpha(b) || is_digit(b)) begin
                    if (len_reg < LEN_BITS'(KEYWORD_MAX_LEN))
                        kbuf_next = kbuf_reg | (64'(b) << {len_reg[2:0], 3'b000});
                    else
                        long_next = 1'b1;
                    len_next = sat_inc(len_reg);
                end else begin
                    res_next[nres] = mk(ident_kind(kbuf_reg, len_reg, long_reg), ERR_NONE,
                                        ts_line_next, ts_col_next, ts_off_next, len_next);
                    nres = nres + 1'b1;
                    mode_next = M_IDLE;
                    rescan = 1'b1;
                end
            end
            M_INT, M_FRAC, M_EXPDIG:
            begin
                if (is_digit(b)) begin
                    len_next = sat_inc(len_reg);
                end else if (b == "." && mode_reg == M_INT) begin
                    len_next = sat_inc(len_reg);
                    mode_next = M_FRAC;
                end else if ((b == "e" || b == "E") && mode_reg != M_EXPDIG) begin
                    len_next = sat_inc(len_reg);
                    mode_next = M_EXP;
                end else begin
                    res_next[nres] = mk((mode_reg == M_INT) ? K_INTLIT : K_FLOATLIT,
                                        ERR_NONE, ts_line_next, ts_col_next,
                                        ts_off_next, len_next);
                    nres = nres + 1'b1;
                    mode_next = M_IDLE;
                    rescan = 1'b1;
                end
            end
            M_EXP, M_EXPSIGN:
            begin
                if ((b == "+" || b == "-") && mode_reg == M_EXP) begin
                    len_next = sat_inc(len_reg);
                    mode_next = M_EXPSIGN;
                end else if (is_digit(b)) begin
                    len_next = sat_inc(len_reg);
                    mode_next = M_EXPDIG;
                end else begin
                    res_next[nres] = mk(K_NONE, ERR_EXPDIG, ts_line_next, ts_col_next,
                                        ts_off_next, '0);
                    nres = nres + 1'b1;
                    mode_next = M_ERROR;
                end
            end
            M_CHOPEN, M_CHESC:
            begin
                if (b == 8'h0a) begin
                    res_next[nres] = mk(K_NONE, ERR_CHOPEN, ts_line_next, ts_col_next,
                                        ts_off_next, '0);
                    nres = nres + 1'b1;
                    mode_next = M_ERROR;
                end else begin
                    len_next = sat_inc(len_reg);
                    mode_next = (mode_reg == M_CHOPEN && b == "\\") ? M_CHESC : M_CHCLOSE;
                end
            end
            M_CHCLOSE:
            begin
                if (b != "'") begin
                    res_next[nres] = mk(K_NONE, ERR_CHLONG, ts_line_next, ts_col_next,
                                        ts_off_next, '0);
                    nres = nres + 1'b1;
                    mode_next = M_ERROR;
                end else begin
                    len_next = sat_inc(len_reg);
                    res_next[nres] = mk(K_CHARLIT, ERR_NONE, ts_line_next, ts_col_next,
                                        ts_off_next, len_next);
                    nres = nres + 1'b1;
                    mode_next = M_IDLE;
                end
            end
            M_STR:
            begin
                if (b == 8'h0a) begin
                    res_next[nres] = mk(K_NONE, ERR_STRING, ts_line_next, ts_col_next,
                                        ts_off_next, '0);
                    nres = nres + 1'b1;
                    mode_next = M_ERROR;
                end else begin
                    len_next = sat_inc(len_reg);
                    if (b == "\"") begin
                        res_next[nres] = mk(K_STRLIT, ERR_NONE, ts_line_next, ts_col_next,
                                            ts_off_next, len_next);
                        nres = nres + 1'b1;
                        mode_next = M_IDLE;
                    end else if (b == "\\") begin
                        mode_next = M_STRESC;
                    end
                end
            end
            M_STRESC:
            begin
                len_next = sat_inc(len_reg);
                mode_next = M_STR;
            end
            M_IDLE:
            begin
                rescan = 1'b1;
            end
            default:
            begin
                mode_next = M_ERROR;
            end
        endcase

        // start of a token from between tokens
        if (rescan && !(b == " " || b == 8'h09 || b == 8'h0d || b == 8'h0a)) begin
            ts_line_next = line_reg;
            ts_col_next  = col_reg;
            ts_off_next  = off_reg;
            len_next     = LEN_BITS'(1);
            kbuf_next    = '0;
            long_next    = 1'b0;
            pend_next    = K_NONE;
            if (is_alpha(b)) begin
                mode_next = M_IDENT;
                kbuf_next = 64'(b);
            end else if (is_digit(b)) begin
                mode_next = M_INT;
            end else if (b == "'") begin
                mode_next = M_CHOPEN;
            end else if (b == "\"") begin
                mode_next = M_STR;
            end else if (op_lead(b) != K_NONE) begin
                mode_next = M_OP;
                pend_next = op_lead(b);
            end else if (op_single(b) != K_NONE) begin
                res_next[nres] = mk(op_single(b), ERR_NONE, ts_line_next, ts_col_next,
                                    ts_off_next, LEN_BITS'(1));
                nres = nres + 1'b1;
            end else begin
                res_next[nres] = mk(K_NONE, ERR_BADCHAR, ts_line_next, ts_col_next,
                                    ts_off_next, '0);
                nres = nres + 1'b1;
                mode_next = M_ERROR;
            end
        end

        // position tracking
        if (b == 8'h0a) begin
            line_next = (line_reg == '1) ? line_reg : line_reg + 1'b1;
            col_next  = POSITION_BITS'(1);
        end else begin
            line_next = line_reg;
            col_next  = (col_reg == '1) ? col_reg : col_reg + 1'b1;
        end
        off_next = off_reg + 1'b1;

        // end of source
        if (s_axis_tlast) begin
            case (mode_next)
                M_OP:
                begin
                    res_next[nres] = mk(pend_next, ERR_NONE, ts_line_next, ts_col_next,
                                        ts_off_next, len_next);
                    nres = nres + 1'b1;
                end
                M_IDENT:
                begin
                    res_next[nres] = mk(ident_kind(kbuf_next, len_next, long_next),
                                        ERR_NONE, ts_line_next, ts_col_next,
                                        ts_off_next, len_next);
                    nres = nres + 1'b1;
                end
                M_INT, M_FRAC, M_EXPDIG:
                begin
                    res_next[nres] = mk((mode_next == M_INT) ? K_INTLIT : K_FLOATLIT,
                                        ERR_NONE, ts_line_next, ts_col_next,
                                        ts_off_next, len_next);
                    nres = nres + 1'b1;
                end
                M_EXP, M_EXPSIGN, M_CHOPEN, M_CHESC, M_CHCLOSE, M_STR, M_STRESC:
                begin
                    res_next[nres] = mk(K_NONE,
                        (mode_next == M_EXP || mode_next == M_EXPSIGN) ? ERR_EXPDIG :
                        (mode_next == M_CHCLOSE) ? ERR_CHLONG :
                        (mode_next == M_CHOPEN || mode_next == M_CHESC) ? ERR_CHOPEN :
                        ERR_STRING,
                        ts_line_next, ts_col_next, ts_off_next, '0);
                    nres = nres + 1'b1;
                    mode_next = M_ERROR;
                end
                default:
                begin
                end
            endcase
            if (mode_next != M_ERROR) begin
                res_next[nres] = mk(K_EOF, ERR_NONE, line_next, col_next, off_next, '0);
                nres = nres + 1'b1;
            end
            mode_next    = M_IDLE;
            pend_next    = K_NONE;
            line_next    = POSITION_BITS'(1);
            col_next     = POSITION_BITS'(1);
            off_next     = '0;
            ts_line_next = POSITION_BITS'(1);
            ts_col_next  = POSITION_BITS'(1);
            ts_off_next  = '0;
            len_next     = '0;
            kbuf_next    = '0;
            long_next    = 1'b0;
        end

        // mark last token of this byte
        if (nres != 2'd0)
            res_next[nres - 1'b1].last = 1'b1;
    end

    // scanner state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg    <= M_IDLE;
            pend_reg    <= K_NONE;
            line_reg    <= POSITION_BITS'(1);
            col_reg     <= POSITION_BITS'(1);
            off_reg     <= '0;
            ts_line_reg <= POSITION_BITS'(1);
            ts_col_reg  <= POSITION_BITS'(1);
            ts_off_reg  <= '0;
            len_reg     <= '0;
            kbuf_reg    <= '0;
            long_reg    <= 1'b0;
        end else if (in_fire) begin
            mode_reg    <= mode_next;
            pend_reg    <= pend_next;
            line_reg    <= line_next;
            col_reg     <= col_next;
            off_reg     <= off_next;
            ts_line_reg <= ts_line_next;
            ts_col_reg  <= ts_col_next;
            ts_off_reg  <= ts_off_next;
            len_reg     <= len_next;
            kbuf_reg    <= kbuf_next;
            long_reg    <= long_next;
        end
    end

    // pending token count and read pointer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            count_reg <= 2'd0;
            head_reg  <= 2'd0;
        end else if (in_fire) begin
            count_reg <= nres;
            head_reg  <= 2'd0;
        end else if (out_fire) begin
            count_reg <= count_reg - 1'b1;
            head_reg  <= head_reg + 1'b1;
        end
    end

    // token payload
    always_ff @(posedge clk)
    begin
        if (in_fire) begin
            for (int i = 0; i < MAX_RESULTS; i++)
                res_reg[i] <= res_next[i];
        end
    end

    // output channel
    result_t head_res;
    always_comb
    begin
        case (head_reg)
            2'd0:    head_res = res_reg[0];
            2'd1:    head_res = res_reg[1];
            default: head_res = res_reg[2];
        endcase
    end

    assign m_axis_tvalid = (count_reg != 2'd0);
    assign m_axis_tlast  = head_res.last;
    assign m_axis_tdata  = {6'd0, head_res.length, head_res.offset, head_res.column,
                            head_res.line, head_res.err, head_res.kind};

endmodule

// ----- dv/c_subset_token_scanner_top_tb.sv -----
`timescale 1ns / 1ps

module c_subset_token_scanner_top_tb;
    import cst_pkg::*;

    typedef struct packed {
        logic [KIND_BITS-1:0] kind;
        logic [ERR_BITS-1:0]  err;
        logic [15:0]          line;
        logic [15:0]          column;
        logic [31:0]          offset;
        logic [15:0]          length;
        logic                 last;
    } token_t;

    localparam int CLK_HALF = 6;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [95:0] m_axis_tdata;
    logic        m_axis_tlast;

    c_subset_token_scanner_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // scanner state mirror
    scan_mode_t           sc_mode;
    logic [KIND_BITS-1:0] sc_pend_op;
    logic [15:0]          sc_line;
    logic [15:0]          sc_col;
    logic [31:0]          sc_off;
    logic [15:0]          sc_tok_line;
    logic [15:0]          sc_tok_col;
    logic [31:0]          sc_tok_off;
    logic [15:0]          sc_len;
    logic [63:0]          sc_kwbuf;
    logic                 sc_long;

    token_t expected_tokens[$];
    token_t step_tokens[$];
    int     error_count;
    logic   hold_off;
    int     hold_cycles;

    string  kw_list[24] = '{"int", "float", "char", "void", "if", "else", "while", "for",
        "return", "break", "continue", "do", "switch", "case", "default", "goto",
        "sizeof", "const", "static", "extern", "volatile", "struct", "union", "enum"};

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("c_subset_token_scanner_top test failed");
        $finish;
    end

    function automatic logic alpha_b(input logic [7:0] b);
        return (b >= 8'h61 && b <= 8'h7a) || (b >= 8'h41 && b <= 8'h5a) || b == 8'h5f;
    endfunction

    function automatic logic digit_b(input logic [7:0] b);
        return b >= 8'h30 && b <= 8'h39;
    endfunction

    function automatic logic [KIND_BITS-1:0] lead_kind(input logic [7:0] b);
        case (b)
            "+": return OP_PLUS;
            "-": return OP_MINUS;
            "*": return OP_STAR;
            "/": return OP_SLASH;
            "=": return OP_ASSIGN;
            "!": return OP_NOT;
            "<": return OP_LT;
            ">": return OP_GT;
            "&": return OP_AND;
            "|": return OP_OR;
            "^": return OP_XOR;
            default: return K_NONE;
        endcase
    endfunction

    function automatic logic [KIND_BITS-1:0] single_kind(input logic [7:0] b);
        case (b)
            "~": return OP_TILDE;
            "?": return OP_QUEST;
            ":": return OP_COLON;
            "(": return OP_LPAREN;
            ")": return OP_RPAREN;
            "{": return OP_LBRACE;
            "}": return OP_RBRACE;
            "[": return OP_LBRACK;
            "]": return OP_RBRACK;
            ";": return OP_SEMI;
            ",": return OP_COMMA;
            ".": return OP_DOT;
            default: return K_NONE;
        endcase
    endfunction

    function automatic logic [KIND_BITS-1:0] joined_kind(input logic [KIND_BITS-1:0] p,
                                                         input logic [7:0] b);
        if (p == OP_PLUS && b == "+") return OP_INC;
        if (p == OP_PLUS && b == "=") return OP_ADDEQ;
        if (p == OP_MINUS && b == ">") return OP_ARROW;
        if (p == OP_MINUS && b == "-") return OP_DEC;
        if (p == OP_MINUS && b == "=") return OP_SUBEQ;
        if (p == OP_STAR && b == "=") return OP_MULEQ;
        if (p == OP_SLASH && b == "=") return OP_DIVEQ;
        if (p == OP_ASSIGN && b == "=") return OP_EQEQ;
        if (p == OP_NOT && b == "=") return OP_NE;
        if (p == OP_LT && b == "<") return OP_SHL;
        if (p == OP_LT && b == "=") return OP_LE;
        if (p == OP_GT && b == ">") return OP_SHR;
        if (p == OP_GT && b == "=") return OP_GE;
        if (p == OP_SHL && b == "=") return OP_SHLEQ;
        if (p == OP_SHR && b == "=") return OP_SHREQ;
        if (p == OP_AND && b == "&") return OP_ANDAND;
        if (p == OP_AND && b == "=") return OP_ANDEQ;
        if (p == OP_OR && b == "|") return OP_OROR;
        if (p == OP_OR && b == "=") return OP_OREQ;
        if (p == OP_XOR && b == "=") return OP_XOREQ;
        return K_NONE;
    endfunction

    // keyword lookup on the first eight bytes of an identifier
    function automatic logic [KIND_BITS-1:0] word_kind();
        logic [63:0] w;
        if (sc_long || sc_len > 16'd8) return K_IDENT;
        for (int i = 0; i < 24; i++)
        begin
            w = '0;
            for (int n = 0; n < kw_list[i].len(); n++)
                w[8*n +: 8] = kw_list[i][n];
            if (kw_list[i].len() == sc_len && w == sc_kwbuf) return KIND_BITS'(i);
        end
        return K_IDENT;
    endfunction

    function automatic void emit_token(input logic [KIND_BITS-1:0] k,
                                       input logic [ERR_BITS-1:0] e, input logic [15:0] n);
        token_t t;
        t.kind   = k;
        t.err    = e;
        t.line   = sc_tok_line;
        t.column = sc_tok_col;
        t.offset = sc_tok_off;
        t.length = n;
        t.last   = 1'b0;
        step_tokens.insert(step_tokens.size(), t);
    endfunction

    function automatic void raise_error(input logic [ERR_BITS-1:0] e);
        emit_token(K_NONE, e, 16'd0);
        sc_mode = M_ERROR;
    endfunction

    function automatic void bump_len();
        if (sc_len != 16'hFFFF) sc_len++;
    endfunction

    function automatic void clear_scanner();
        sc_mode     = M_IDLE;
        sc_pend_op  = '0;
        sc_line     = 16'd1;
        sc_col      = 16'd1;
        sc_off      = '0;
        sc_tok_line = 16'd1;
        sc_tok_col  = 16'd1;
        sc_tok_off  = '0;
        sc_len      = '0;
        sc_kwbuf    = '0;
        sc_long     = 1'b0;
    endfunction

    function automatic void start_token(input logic [7:0] b);
        if (b == 8'h20 || b == 8'h09 || b == 8'h0d || b == 8'h0a) return;
        sc_tok_line = sc_line;
        sc_tok_col  = sc_col;
        sc_tok_off  = sc_off;
        sc_len      = 16'd1;
        sc_kwbuf    = '0;
        sc_long     = 1'b0;
        sc_pend_op  = '0;
        if (alpha_b(b))
        begin
            sc_mode  = M_IDENT;
            sc_kwbuf = {56'd0, b};
        end
        else if (digit_b(b)) sc_mode = M_INT;
        else if (b == 8'h27) sc_mode = M_CHOPEN;
        else if (b == 8'h22) sc_mode = M_STR;
        else if (lead_kind(b) != K_NONE)
        begin
            sc_mode    = M_OP;
            sc_pend_op = lead_kind(b);
        end
        else if (single_kind(b) != K_NONE) emit_token(single_kind(b), ERR_NONE, 16'd1);
        else raise_error(ERR_BADCHAR);
    endfunction

    // returns 1 when the byte must be scanned again as a token start
    function automatic logic advance_mode(input logic [7:0] b);
        logic [KIND_BITS-1:0] k;
        case (sc_mode)
            M_IDLE:
            begin
                start_token(b);
                return 1'b0;
            end
            M_COMMENT:
            begin
                if (b == 8'h0a) sc_mode = M_IDLE;
                return 1'b0;
            end
            M_OP:
            begin
                if (sc_pend_op == OP_SLASH && b == "/")
                begin
                    sc_mode = M_COMMENT;
                    return 1'b0;
                end
                k = joined_kind(sc_pend_op, b);
                if (k == K_NONE)
                begin
                    emit_token(sc_pend_op, ERR_NONE, sc_len);
                    sc_mode = M_IDLE;
                    return 1'b1;
                end
                bump_len();
                if (k == OP_SHL || k == OP_SHR)
                begin
                    sc_pend_op = k;
                    return 1'b0;
                end
                emit_token(k, ERR_NONE, sc_len);
                sc_mode = M_IDLE;
                return 1'b0;
            end
            M_IDENT:
            begin
                if (alpha_b(b) || digit_b(b))
                begin
                    if (sc_len < 16'd8) sc_kwbuf[8*sc_len[2:0] +: 8] = b;
                    else sc_long = 1'b1;
                    bump_len();
                    return 1'b0;
                end
                emit_token(word_kind(), ERR_NONE, sc_len);
                sc_mode = M_IDLE;
                return 1'b1;
            end
            M_INT, M_FRAC:
            begin
                if (digit_b(b))
                begin
                    bump_len();
                    return 1'b0;
                end
                if (b == "." && sc_mode == M_INT)
                begin
                    bump_len();
                    sc_mode = M_FRAC;
                    return 1'b0;
                end
                if (b == "e" || b == "E")
                begin
                    bump_len();
                    sc_mode = M_EXP;
                    return 1'b0;
                end
                emit_token(sc_mode == M_INT ? K_INTLIT : K_FLOATLIT, ERR_NONE, sc_len);
                sc_mode = M_IDLE;
                return 1'b1;
            end
            M_EXP, M_EXPSIGN:
            begin
                if (sc_mode == M_EXP && (b == "+" || b == "-"))
                begin
                    bump_len();
                    sc_mode = M_EXPSIGN;
                end
                else if (digit_b(b))
                begin
                    bump_len();
                    sc_mode = M_EXPDIG;
                end
                else raise_error(ERR_EXPDIG);
                return 1'b0;
            end
            M_EXPDIG:
            begin
                if (digit_b(b))
                begin
                    bump_len();
                    return 1'b0;
                end
                emit_token(K_FLOATLIT, ERR_NONE, sc_len);
                sc_mode = M_IDLE;
                return 1'b1;
            end
            M_CHOPEN, M_CHESC:
            begin
                if (b == 8'h0a) raise_error(ERR_CHOPEN);
                else
                begin
                    bump_len();
                    sc_mode = (sc_mode == M_CHOPEN && b == 8'h5c) ? M_CHESC : M_CHCLOSE;
                end
                return 1'b0;
            end
            M_CHCLOSE:
            begin
                if (b != 8'h27) raise_error(ERR_CHLONG);
                else
                begin
                    bump_len();
                    emit_token(K_CHARLIT, ERR_NONE, sc_len);
                    sc_mode = M_IDLE;
                end
                return 1'b0;
            end
            M_STR:
            begin
                if (b == 8'h0a) raise_error(ERR_STRING);
                else
                begin
                    bump_len();
                    if (b == 8'h22)
                    begin
                        emit_token(K_STRLIT, ERR_NONE, sc_len);
                        sc_mode = M_IDLE;
                    end
                    else if (b == 8'h5c) sc_mode = M_STRESC;
                end
                return 1'b0;
            end
            M_STRESC:
            begin
                bump_len();
                sc_mode = M_STR;
                return 1'b0;
            end
            default:
            begin
                sc_mode = M_ERROR;
                return 1'b0;
            end
        endcase
    endfunction

    function automatic void close_source();
        case (sc_mode)
            M_OP:                emit_token(sc_pend_op, ERR_NONE, sc_len);
            M_IDENT:             emit_token(word_kind(), ERR_NONE, sc_len);
            M_INT:               emit_token(K_INTLIT, ERR_NONE, sc_len);
            M_FRAC, M_EXPDIG:    emit_token(K_FLOATLIT, ERR_NONE, sc_len);
            M_EXP, M_EXPSIGN:    raise_error(ERR_EXPDIG);
            M_CHOPEN, M_CHESC:   raise_error(ERR_CHOPEN);
            M_CHCLOSE:           raise_error(ERR_CHLONG);
            M_STR, M_STRESC:     raise_error(ERR_STRING);
            default: ;
        endcase
        if (sc_mode != M_ERROR)
        begin
            sc_tok_line = sc_line;
            sc_tok_col  = sc_col;
            sc_tok_off  = sc_off;
            emit_token(K_EOF, ERR_NONE, 16'd0);
        end
        clear_scanner();
    endfunction

    // tokens caused by one source byte, appended to the expected queue
    function automatic void predict_tokens(input logic [7:0] b, input logic last_byte);
        step_tokens.delete();
        if (advance_mode(b)) start_token(b);
        if (b == 8'h0a)
        begin
            if (sc_line != 16'hFFFF) sc_line++;
            sc_col = 16'd1;
        end
        else if (sc_col != 16'hFFFF) sc_col++;
        sc_off++;
        if (last_byte) close_source();
        if (step_tokens.size() > 0) step_tokens[step_tokens.size()-1].last = 1'b1;
        foreach (step_tokens[i]) expected_tokens.insert(expected_tokens.size(), step_tokens[i]);
    endfunction

    // sender: one byte per handshake with a random gap before it
    task automatic send_byte(input logic [7:0] b, input logic last_byte);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
        if ($urandom_range(0, 1) == 0) gap = 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last_byte;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        predict_tokens(b, last_byte);
        @(negedge clk);
    endtask

    task automatic send_text(input string s, input logic close);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], close && i == s.len() - 1);
    endtask

    // receiver: random stalls, or a long hold when asked
    initial
    begin
        int stall;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off)
            begin
                m_axis_tready <= 1'b0;
                repeat (hold_cycles) @(negedge clk);
                hold_off = 1'b0;
            end
            else
            begin
                stall = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 17) : 0;
                if (stall > 0)
                begin
                    m_axis_tready <= 1'b0;
                    repeat (stall) @(negedge clk);
                end
            end
            m_axis_tready <= 1'b1;
        end
    end

    // result checker
    initial
    begin
        token_t got;
        token_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
            begin
                got = {m_axis_tdata[6:0], m_axis_tdata[9:7], m_axis_tdata[25:10],
                       m_axis_tdata[41:26], m_axis_tdata[73:42], m_axis_tdata[89:74],
                       m_axis_tlast};
                if (expected_tokens.size() == 0)
                begin
                    $display("%0t: unexpected token, expected none, actual %h", $time, got);
                    error_count++;
                end
                else
                begin
                    want = expected_tokens.pop_front();
                    if (got !== want)
                    begin
                        $display("%0t: token mismatch kind %0d/%0d err %0d/%0d line %0d/%0d",
                                 $time, want.kind, got.kind, want.err, got.err,
                                 want.line, got.line);
                        $display("%0t:   col %0d/%0d off %0d/%0d len %0d/%0d last %0d/%0d",
                                 $time, want.column, got.column, want.offset, got.offset,
                                 want.length, got.length, want.last, got.last);
                        error_count++;
                    end
                end
            end
        end
    end

    task automatic test_keywords_and_operators();
        send_text("int float char void if else while for return break continue do ", 1'b0);
        send_text("switch case default goto sizeof const static extern volatile ", 1'b0);
        send_text("struct union enum volatilex _a9Z continuex\n", 1'b0);
        send_text("+ - * / == != < > <= >= && || ! & | ^ ~ << >> ? : ++ -- += -= ", 1'b0);
        send_text("*= /= &= |= ^= <<= >>= = ( ) { } [ ] ; , . -> a<<=b>>c", 1'b1);
    endtask

    task automatic test_literals_and_comments();
        send_text("12 3.5 1e9 2.5E-3 7e+1 'a' '\\n' \"s\\\"x\\\n\" // note\nx", 1'b1);
        send_text("x/y//c\n", 1'b1);
        send_text("1e", 1'b1);
        send_text("2e+ ", 1'b1);
        send_text("'", 1'b1);
        send_text("'ab' q", 1'b1);
        send_text("'\n", 1'b1);
        send_text("\"open", 1'b1);
        send_text("a # b", 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b1);
        send_text("<<", 1'b1);
    endtask

    // mostly well-formed fragments, some noise bytes
    task automatic test_random_source();
        string frag[] = '{"int ", "x1", " = ", "42", "3.14e-2", "'c'", "\"str\\n\"",
                          "// rem\n", "\n", "\t", "while", "(", ")", "->", "<<=", "++",
                          "_long_identifier_name", "1e", "'xy'", "sizeof", "&&", ";"};
        int sent;
        sent = 0;
        while (sent < 150)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
                sent++;
            end
            else
            begin
                string s;
                s = frag[$urandom_range(0, frag.size() - 1)];
                send_text(s, $urandom_range(0, 20) == 0);
                sent += s.len();
            end
        end
        send_byte(";", 1'b1);
    endtask

    task automatic test_backpressure();
        hold_cycles = 200;
        hold_off    = 1'b1;
        send_text("a+b;c*d;e<<f;g->h;i", 1'b1);
    endtask

    initial
    begin
        int waited;
        error_count   = 0;
        hold_off      = 1'b0;
        hold_cycles   = 0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        clear_scanner();
        rst_n = 1'b0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        test_keywords_and_operators();
        test_literals_and_comments();
        test_backpressure();
        test_random_source();
        s_axis_tvalid <= 1'b0;

        waited = 0;
        while (expected_tokens.size() > 0 && waited < 100000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (40) @(posedge clk);
        if (expected_tokens.size() > 0)
        begin
            $display("%0t: %0d tokens never arrived", $time, expected_tokens.size());
            error_count++;
        end
        if (error_count == 0)
            $display("c_subset_token_scanner_top test passed");
        else
            $display("c_subset_token_scanner_top test failed");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/cst_pkg.sv
rtl/c_subset_token_scanner_top.sv
dv/c_subset_token_scanner_top_tb.sv
